>>> rtl/core/leb128_pkg.sv
// ----------------------------------------------------------------------------
// LEB128 decoder package
// Shared constants, result type and width helpers for the LEB128 decoder.
// ----------------------------------------------------------------------------
package leb128_pkg;

    localparam int MAX_VALUE_BYTES = 8;    // widest decoded value, 1..8 bytes
    localparam int VALUE_W         = 64;
    localparam int STATUS_W        = 2;
    localparam int USED_W          = 4;
    localparam int WIDTH_W         = 4;
    localparam int S_TDATA_W       = 16;   // data_byte, value_bytes, zero pad
    localparam int M_TDATA_W       = 72;   // decoded_value, bytes_used, zero pad

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FORMAT   = 2'd1;  // too long or truncated
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
        logic [USED_W-1:0]   used;
    } t_result;

    // Maximum number of encoded bytes for a width: ceil(8*w/7)
    function automatic logic [USED_W-1:0] max_enc_bytes(input logic [WIDTH_W-1:0] w);
        logic [USED_W-1:0] n;
        case (w)
            4'd1:    n = 4'd2;
            4'd2:    n = 4'd3;
            4'd3:    n = 4'd4;
            4'd4:    n = 4'd5;
            4'd5:    n = 4'd6;
            4'd6:    n = 4'd7;
            4'd7:    n = 4'd8;
            default: n = 4'd10;
        endcase
        return n;
    endfunction

    // Clamp a requested width into 1..wmax
    function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] w,
                                                        input logic [WIDTH_W-1:0] wmax);
        logic [WIDTH_W-1:0] c;
        if (w == '0) begin
            c = 4'd1;
        end else if (w > wmax) begin
            c = wmax;
        end else begin
            c = w;
        end
        return c;
    endfunction

endpackage

>>> rtl/core/leb128_stream_decoder.sv
// ----------------------------------------------------------------------------
// LEB128 stream decoder
// Takes one encoded byte per request; gives one result per completed,
// truncated, over-long or overflowing value.
// Result of the final byte is registered for o_m_* (into the skid if o_m_* is stalled).
// Throughput: one byte per cycle unless the skid is full; shift, mask and compare logic only.
// A two-deep output (result register plus skid) absorbs one result under stall; then input is held off.
// Reset (i_rst_n low, synchronous): no value in progress, output empty.
// ----------------------------------------------------------------------------
module leb128_stream_decoder #(
    parameter int MAX_BYTES = leb128_pkg::MAX_VALUE_BYTES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [leb128_pkg::S_TDATA_W-1:0] i_s_tdata,  // [7:0] data_byte, [11:8] value_bytes
    input  logic                             i_s_tuser,  // [0] signed_mode
    input  logic                             i_s_tlast,  // end_of_buffer
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [leb128_pkg::M_TDATA_W-1:0] o_m_tdata,  // [63:0] decoded_value, [67:64] bytes_used
    output logic [leb128_pkg::STATUS_W-1:0]  o_m_tuser   // [1:0] status
);
    import leb128_pkg::*;

    // decode state
    logic [VALUE_W-1:0] r_acc,    n_acc;
    logic [USED_W-1:0]  r_idx,    n_idx;
    logic [WIDTH_W-1:0] r_width,  n_width;
    logic               r_signed, n_signed;

    // output register and skid
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;

    logic               accept, out_fire;
    logic               first;
    logic [7:0]         b;
    logic [WIDTH_W-1:0] w;
    logic               sgn;
    logic [6:0]         nbits, base, top;
    logic [6:0]         in_range;
    logic [VALUE_W-1:0] wmask, shifted, acc_cur, fill;
    logic               expect_bit, ovf;
    logic [USED_W:0]    used_ext;
    logic [USED_W-1:0]  used;
    logic               res_valid;
    t_result            res;

    assign accept   = i_s_tvalid & o_s_tready;
    assign out_fire = r_out_valid & i_m_tready;
    assign b        = i_s_tdata[7:0];
    assign first    = (r_idx == '0);
    assign w        = first ? clamp_width(i_s_tdata[11:8], WIDTH_W'(MAX_BYTES)) : r_width;
    assign sgn      = first ? i_s_tuser : r_signed;

    assign nbits = {w[3:0], 3'b000};
    assign base  = 7'(7) * {3'b000, r_idx};
    assign top   = base + 7'd7;

    always_comb begin
        for (int g = 0; g < 8; g++) begin
            wmask[g*8 +: 8] = (4'(g) < w) ? 8'hFF : 8'h00;
        end
        for (int j = 0; j < 7; j++) begin
            in_range[j] = ((base + 7'(j)) < nbits);
        end
    end

    assign shifted    = {57'b0, b[6:0]} << base[5:0];
    assign acc_cur    = (first ? '0 : r_acc) | (shifted & wmask);
    assign expect_bit = sgn & b[6];
    assign ovf        = |((b[6:0] ^ {7{expect_bit}}) & ~in_range);
    // sign fill of the bits above the last group, inside the width
    assign fill       = (sgn && b[6] && (top < nbits)) ? (({VALUE_W{1'b1}} << top[5:0]) & wmask)
                                                       : '0;
    assign used_ext   = {1'b0, r_idx} + 5'd1;
    assign used       = used_ext[USED_W-1:0];

    always_comb begin
        res_valid  = 1'b0;
        res.value  = '0;
        res.status = ST_OK;
        res.used   = used;
        n_acc      = r_acc;
        n_idx      = r_idx;
        n_width    = r_width;
        n_signed   = r_signed;
        if (accept) begin
            n_width  = w;
            n_signed = sgn;
            if (b[7]) begin
                if ((used_ext >= {1'b0, max_enc_bytes(w)}) || i_s_tlast) begin
                    res_valid  = 1'b1;
                    res.status = ST_FORMAT;
                    n_acc      = '0;
                    n_idx      = '0;
                end else begin
                    n_acc = acc_cur;
                    n_idx = used;
                end
            end else begin
                res_valid = 1'b1;
                if (ovf) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    res.value = (acc_cur | fill) & wmask;
                end
                n_acc = '0;
                n_idx = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_idx    <= '0;
            r_width  <= 4'd1;
            r_signed <= 1'b0;
        end else begin
            r_acc    <= n_acc;
            r_idx    <= n_idx;
            r_width  <= n_width;
            r_signed <= n_signed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // input is held off while the skid is full
            if (out_fire) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_fire) begin
            r_out_valid <= res_valid;
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || out_fire) begin
            r_out <= res;
        end else begin
            r_skid <= res;
        end
    end

    assign o_s_tready = !r_skid_valid;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out.used, r_out.value};
    assign o_m_tuser  = r_out.status;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while output register is empty");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != ST_OK)) |-> (o_m_tdata[63:0] == '0))
        else $error("failed decode carries a non-zero value");

    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata[67:64] != 4'd0) && (o_m_tdata[67:64] <= 4'd10)))
        else $error("bytes used out of range");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= 4'd9)
        else $error("byte index past longest encoding");
`endif

endmodule
